[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cau_pkg.sv]
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int FRAC_BITS_DEF    = 12;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int OP_W        = 3;
  localparam int GUARD_BITS  = 8;
  localparam int ANGLE_FRAC  = 30;
  localparam int ZW          = 35;
  localparam int GAIN_W      = 22;
  localparam int MAG_SHIFT   = GAIN_W + GUARD_BITS;
  localparam int WIDE_W      = 66;

  localparam logic signed [ZW-1:0]   PI_Q30       = 35'sd3373259426;
  localparam logic [GAIN_W-1:0]      INV_GAIN_Q22 = 22'd2547003;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_EQ    = 3'd3,
    OP_MAG   = 3'd4,
    OP_PHASE = 3'd5
  } op_t;

  typedef struct packed {
    op_t  op;
    logic eq;
    logic sat;
    logic zero;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 35'sd843314856;
      5'd1:    v = 35'sd497837829;
      5'd2:    v = 35'sd263043836;
      5'd3:    v = 35'sd133525158;
      5'd4:    v = 35'sd67021686;
      5'd5:    v = 35'sd33543515;
      5'd6:    v = 35'sd16775850;
      5'd7:    v = 35'sd8388437;
      5'd8:    v = 35'sd4194282;
      5'd9:    v = 35'sd2097149;
      5'd10:   v = 35'sd1048575;
      5'd11:   v = 35'sd524287;
      5'd12:   v = 35'sd262143;
      5'd13:   v = 35'sd131071;
      5'd14:   v = 35'sd65535;
      5'd15:   v = 35'sd32767;
      5'd16:   v = 35'sd16383;
      5'd17:   v = 35'sd8191;
      5'd18:   v = 35'sd4095;
      5'd19:   v = 35'sd2047;
      5'd20:   v = 35'sd1023;
      5'd21:   v = 35'sd511;
      5'd22:   v = 35'sd255;
      5'd23:   v = 35'sd127;
      5'd24:   v = 35'sd63;
      5'd25:   v = 35'sd31;
      5'd26:   v = 35'sd15;
      5'd27:   v = 35'sd7;
      5'd28:   v = 35'sd3;
      5'd29:   v = 35'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // True when v lies outside the signed dw-bit range.
  function automatic logic sat_hit(input logic signed [WIDE_W-1:0] v, input int unsigned dw);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) <<< (dw - 1)) - WIDE_W'(1);
    lo = ~hi;
    return (v > hi) || (v < lo);
  endfunction

  // Clamp v to the signed dw-bit range.
  function automatic logic signed [WIDE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v,
                                                       input int unsigned dw);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = (WIDE_W'(1) <<< (dw - 1)) - WIDE_W'(1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[src/cau_pre.sv]
`default_nettype none
module cau_pre import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic [OP_W-1:0]                             in_operation,
  input  wire logic signed [DATA_WIDTH-1:0]                in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0]                in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0]                in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0]                in_b_im,
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output ctl_t                                             out_ctl,
  output logic signed [DATA_WIDTH+GUARD_BITS+2:0]          out_x,
  output logic signed [DATA_WIDTH+GUARD_BITS+2:0]          out_y,
  output logic signed [ZW-1:0]                             out_z
);

  localparam int CW = DATA_WIDTH + GUARD_BITS + 3;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int RW = PW + 2;
  localparam int SW = DATA_WIDTH + 1;
  localparam logic signed [RW-1:0] RND = RW'(1) <<< (FRAC_BITS - 1);

  // Stage A: operands and partial products
  logic                         va_r;
  op_t                          op_a_r;
  logic signed [DATA_WIDTH-1:0] are_r, aim_r, bre_r, bim_r;
  logic signed [PW-1:0]         p_rr_r, p_ii_r, p_ri_r, p_ir_r;

  // Stage B: combined result or CORDIC start vector
  logic                         vb_r;
  ctl_t                         ctl_r;
  logic signed [CW-1:0]         x_r, y_r;
  logic signed [ZW-1:0]         z_r;

  logic                         ready_b;
  logic                         load_a, load_b;

  logic signed [SW-1:0]         s_re, s_im, d_re, d_im;
  logic signed [RW-1:0]         m_re_sum, m_im_sum, m_re, m_im;
  logic signed [WIDE_W-1:0]     re_w, im_w, re_c, im_c;
  logic signed [CW-1:0]         xs, ys;

  ctl_t                         ctl_nxt;
  logic signed [CW-1:0]         x_nxt, y_nxt;
  logic signed [ZW-1:0]         z_nxt;

  assign ready_b  = !vb_r || out_ready;
  assign in_ready = !va_r || ready_b;
  assign load_a   = in_valid && in_ready;
  assign load_b   = va_r && ready_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (in_ready) begin
      va_r <= in_valid;
    end
    if (load_a) begin
      op_a_r <= op_t'(in_operation);
      are_r  <= in_a_re;
      aim_r  <= in_a_im;
      bre_r  <= in_b_re;
      bim_r  <= in_b_im;
      p_rr_r <= PW'(in_a_re) * PW'(in_b_re);
      p_ii_r <= PW'(in_a_im) * PW'(in_b_im);
      p_ri_r <= PW'(in_a_re) * PW'(in_b_im);
      p_ir_r <= PW'(in_a_im) * PW'(in_b_re);
    end
  end

  assign s_re = SW'(are_r) + SW'(bre_r);
  assign s_im = SW'(aim_r) + SW'(bim_r);
  assign d_re = SW'(are_r) - SW'(bre_r);
  assign d_im = SW'(aim_r) - SW'(bim_r);

  // Round half up after dropping the product fraction bits
  assign m_re_sum = RW'(p_rr_r) - RW'(p_ii_r) + RND;
  assign m_im_sum = RW'(p_ri_r) + RW'(p_ir_r) + RND;
  assign m_re     = m_re_sum >>> FRAC_BITS;
  assign m_im     = m_im_sum >>> FRAC_BITS;

  always_comb begin
    re_w = '0;
    im_w = '0;
    case (op_a_r)
      OP_ADD: begin
        re_w = WIDE_W'(s_re);
        im_w = WIDE_W'(s_im);
      end
      OP_SUB: begin
        re_w = WIDE_W'(d_re);
        im_w = WIDE_W'(d_im);
      end
      OP_MUL: begin
        re_w = WIDE_W'(m_re);
        im_w = WIDE_W'(m_im);
      end
      default: begin
      end
    endcase
  end

  assign re_c = sat_val(re_w, DATA_WIDTH);
  assign im_c = sat_val(im_w, DATA_WIDTH);
  assign xs   = CW'(are_r) <<< GUARD_BITS;
  assign ys   = CW'(aim_r) <<< GUARD_BITS;

  always_comb begin
    ctl_nxt      = '0;
    ctl_nxt.op   = op_a_r;
    ctl_nxt.eq   = (op_a_r == OP_EQ) && (are_r == bre_r) && (aim_r == bim_r);
    ctl_nxt.sat  = sat_hit(re_w, DATA_WIDTH) || sat_hit(im_w, DATA_WIDTH);
    ctl_nxt.zero = (are_r == '0) && (aim_r == '0);
    x_nxt        = CW'(re_c);
    y_nxt        = CW'(im_c);
    z_nxt        = '0;
    if ((op_a_r == OP_MAG) || (op_a_r == OP_PHASE)) begin
      // Left half plane: rotate by pi first
      if (are_r < 0) begin
        x_nxt = -xs;
        y_nxt = -ys;
        z_nxt = (aim_r >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_nxt = xs;
        y_nxt = ys;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ready_b) begin
      vb_r <= va_r;
    end
    if (load_b) begin
      ctl_r <= ctl_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_ctl   = ctl_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule
`default_nettype wire

[src/cau_cell.sv]
`default_nettype none
module cau_cell import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int STEP       = 0
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire ctl_t                                in_ctl,
  input  wire logic signed [DATA_WIDTH+GUARD_BITS+2:0] in_x,
  input  wire logic signed [DATA_WIDTH+GUARD_BITS+2:0] in_y,
  input  wire logic signed [ZW-1:0]                in_z,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output ctl_t                                     out_ctl,
  output logic signed [DATA_WIDTH+GUARD_BITS+2:0]  out_x,
  output logic signed [DATA_WIDTH+GUARD_BITS+2:0]  out_y,
  output logic signed [ZW-1:0]                     out_z
);

  localparam int CW = DATA_WIDTH + GUARD_BITS + 3;
  localparam logic signed [ZW-1:0] ANG = atan_q30(5'(STEP));

  logic                 v_r;
  ctl_t                 ctl_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  logic                 rot;
  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  assign in_ready = !v_r || out_ready;
  assign rot      = (in_ctl.op == OP_MAG) || (in_ctl.op == OP_PHASE);
  assign dx       = in_y >>> STEP;
  assign dy       = in_x >>> STEP;

  // Rotate toward the x axis; other requests pass unchanged
  always_comb begin
    x_nxt = in_x;
    y_nxt = in_y;
    z_nxt = in_z;
    if (rot) begin
      if (!in_y[CW-1]) begin
        x_nxt = in_x + dx;
        y_nxt = in_y - dy;
        z_nxt = in_z + ANG;
      end else begin
        x_nxt = in_x - dx;
        y_nxt = in_y + dy;
        z_nxt = in_z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ctl_r <= in_ctl;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_ctl   = ctl_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;

endmodule
`default_nettype wire

[src/cau_post.sv]
`default_nettype none
module cau_post import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire ctl_t                                    in_ctl,
  input  wire logic signed [DATA_WIDTH+GUARD_BITS+2:0] in_x,
  input  wire logic signed [DATA_WIDTH+GUARD_BITS+2:0] in_y,
  input  wire logic signed [ZW-1:0]                    in_z,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [DATA_WIDTH-1:0]                 out_res_re,
  output logic signed [DATA_WIDTH-1:0]                 out_res_im,
  output logic                                         out_equal,
  output logic                                         out_saturated
);

  localparam int CW     = DATA_WIDTH + GUARD_BITS + 3;
  localparam int LO     = (CW - 1) / 2;
  localparam int HW     = CW - 1 - LO;
  localparam int MW     = CW + GAIN_W;
  localparam int PH_SH  = ANGLE_FRAC - FRAC_BITS;
  localparam logic signed [ZW-1:0] RND_Z   = ZW'(1) <<< (PH_SH - 1);
  localparam logic [MW-1:0]        MAG_RND = MW'(1) << (MAG_SHIFT - 1);

  // Stage C: gain partial products, rounded phase
  logic                         vc_r;
  ctl_t                         ctl_c_r;
  logic [LO+GAIN_W-1:0]         plo_r;
  logic [HW+GAIN_W-1:0]         phi_r;
  logic signed [DATA_WIDTH-1:0] ph_r, xp_r, yp_r;
  logic                         ph_sat_r;

  // Stage D: output register
  logic                         vo_r;
  logic signed [DATA_WIDTH-1:0] res_re_r, res_im_r;
  logic                         equal_r, sat_r;

  logic                         ready_d;
  logic [CW-2:0]                xu;
  logic signed [ZW-1:0]         ph_sum, ph_full;
  logic signed [WIDE_W-1:0]     ph_w, mag_w;
  logic [MW-1:0]                mag_sum;
  logic [MW-MAG_SHIFT-1:0]      mag_q;

  logic signed [DATA_WIDTH-1:0] res_re_nxt, res_im_nxt;
  logic                         equal_nxt, sat_nxt;

  assign ready_d  = !vo_r || out_ready;
  assign in_ready = !vc_r || ready_d;

  // x is never negative after the vectoring run
  assign xu      = in_x[CW-2:0];
  assign ph_sum  = in_z + RND_Z;
  assign ph_full = ph_sum >>> PH_SH;
  assign ph_w    = WIDE_W'(ph_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (in_ready) begin
      vc_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      ctl_c_r  <= in_ctl;
      plo_r    <= (LO + GAIN_W)'(xu[LO-1:0]) * (LO + GAIN_W)'(INV_GAIN_Q22);
      phi_r    <= (HW + GAIN_W)'(xu[CW-2:LO]) * (HW + GAIN_W)'(INV_GAIN_Q22);
      ph_r     <= DATA_WIDTH'(sat_val(ph_w, DATA_WIDTH));
      ph_sat_r <= sat_hit(ph_w, DATA_WIDTH);
      xp_r     <= in_x[DATA_WIDTH-1:0];
      yp_r     <= in_y[DATA_WIDTH-1:0];
    end
  end

  assign mag_sum = (MW'(phi_r) << LO) + MW'(plo_r) + MAG_RND;
  assign mag_q   = mag_sum[MW-1:MAG_SHIFT];
  assign mag_w   = WIDE_W'(mag_q);

  always_comb begin
    res_re_nxt = '0;
    res_im_nxt = '0;
    equal_nxt  = 1'b0;
    sat_nxt    = 1'b0;
    case (ctl_c_r.op)
      OP_MAG: begin
        res_re_nxt = DATA_WIDTH'(sat_val(mag_w, DATA_WIDTH));
        sat_nxt    = sat_hit(mag_w, DATA_WIDTH);
      end
      OP_PHASE: begin
        // Zero vector has no angle: report zero
        if (!ctl_c_r.zero) begin
          res_re_nxt = ph_r;
          sat_nxt    = ph_sat_r;
        end
      end
      default: begin
        res_re_nxt = xp_r;
        res_im_nxt = yp_r;
        equal_nxt  = ctl_c_r.eq;
        sat_nxt    = ctl_c_r.sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ready_d) begin
      vo_r <= vc_r;
    end
    if (vc_r && ready_d) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      equal_r  <= equal_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid     = vo_r;
  assign out_res_re    = res_re_r;
  assign out_res_im    = res_im_r;
  assign out_equal     = equal_r;
  assign out_saturated = sat_r;

endmodule
`default_nettype wire

[src/complex_arithmetic_unit.sv]
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------------
// in       | in_valid/in_ready  | in_operation, in_a_re, in_a_im, in_b_re, in_b_im
// out      | out_valid/out_ready| out_res_re, out_res_im, out_equal, out_saturated
//
// One request per cycle while the output side takes results; every operation passes
// through the same path: two front stages, the row of CORDIC cells and two back stages.
// Every stage holds its own valid bit; a stage loads whenever it is empty or
// its neighbor downstream takes its content, so bubbles close up during a stall.
// A synchronous active-low reset empties every stage.
`default_nettype none
`include "assert_macros.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [OP_W-1:0]              in_operation,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_a_im,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_re,
  input  wire logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_res_re,
  output logic signed [DATA_WIDTH-1:0]      out_res_im,
  output logic                              out_equal,
  output logic                              out_saturated
);

  localparam int CW = DATA_WIDTH + GUARD_BITS + 3;
  localparam logic signed [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  logic                 ch_valid [CORDIC_STEPS+1];
  logic                 ch_ready [CORDIC_STEPS+1];
  ctl_t                 ch_ctl   [CORDIC_STEPS+1];
  logic signed [CW-1:0] ch_x     [CORDIC_STEPS+1];
  logic signed [CW-1:0] ch_y     [CORDIC_STEPS+1];
  logic signed [ZW-1:0] ch_z     [CORDIC_STEPS+1];

  logic                 eq_ok;
  logic                 sat_ok;

  cau_pre #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pre (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_a_re      (in_a_re),
    .in_a_im      (in_a_im),
    .in_b_re      (in_b_re),
    .in_b_im      (in_b_im),
    .out_valid    (ch_valid[0]),
    .out_ready    (ch_ready[0]),
    .out_ctl      (ch_ctl[0]),
    .out_x        (ch_x[0]),
    .out_y        (ch_y[0]),
    .out_z        (ch_z[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    cau_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .STEP       (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[i]),
      .in_ready  (ch_ready[i]),
      .in_ctl    (ch_ctl[i]),
      .in_x      (ch_x[i]),
      .in_y      (ch_y[i]),
      .in_z      (ch_z[i]),
      .out_valid (ch_valid[i+1]),
      .out_ready (ch_ready[i+1]),
      .out_ctl   (ch_ctl[i+1]),
      .out_x     (ch_x[i+1]),
      .out_y     (ch_y[i+1]),
      .out_z     (ch_z[i+1])
    );
  end

  cau_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (ch_valid[CORDIC_STEPS]),
    .in_ready      (ch_ready[CORDIC_STEPS]),
    .in_ctl        (ch_ctl[CORDIC_STEPS]),
    .in_x          (ch_x[CORDIC_STEPS]),
    .in_y          (ch_y[CORDIC_STEPS]),
    .in_z          (ch_z[CORDIC_STEPS]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res_re    (out_res_re),
    .out_res_im    (out_res_im),
    .out_equal     (out_equal),
    .out_saturated (out_saturated)
  );

  assign eq_ok  = !out_equal ||
                  ((out_res_re == '0) && (out_res_im == '0) && !out_saturated);
  assign sat_ok = !out_saturated ||
                  (out_res_re == SAT_HI) || (out_res_re == SAT_LO) ||
                  (out_res_im == SAT_HI) || (out_res_im == SAT_LO);

  // A free output side lets every stage advance
  `CAU_ASSERT(a_ready_chain, out_ready |-> in_ready, "input stalled while output is free")
  `CAU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `CAU_ASSERT(a_equal_clean, out_valid |-> eq_ok, "equality result carries data")
  `CAU_ASSERT(a_sat_bound, out_valid |-> sat_ok, "saturation flag without clipped value")

endmodule
`default_nettype wire

[test/cau_checker.sv]
module cau_checker import cau_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [OP_W-1:0]                   in_operation,
  input  logic signed [DATA_WIDTH_DEF-1:0]  in_a_re,
  input  logic signed [DATA_WIDTH_DEF-1:0]  in_a_im,
  input  logic signed [DATA_WIDTH_DEF-1:0]  in_b_re,
  input  logic signed [DATA_WIDTH_DEF-1:0]  in_b_im,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [DATA_WIDTH_DEF-1:0]  out_res_re,
  input  logic signed [DATA_WIDTH_DEF-1:0]  out_res_im,
  input  logic                              out_equal,
  input  logic                              out_saturated,
  output int                                fail_count,
  output int                                pending,
  output int                                checked_count,
  output int                                sat_count,
  output int                                eq_count
);

  localparam int DW    = DATA_WIDTH_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;

  localparam longint RES_MAX = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint RES_MIN = -RES_MAX - 1;

  // atan(2^-i) in Q30, truncated
  localparam longint ARCTAN_Q30 [0:15] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767
  };

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 eq;
    logic                 sat;
  } cplx_result_t;

  cplx_result_t expected_q[$];

  // Vectoring rotation of (xr, yr) toward the positive real axis.
  function automatic void vector_polar(input longint xr, input longint yr,
                                       output longint mag, output longint ang);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = xr * (longint'(1) <<< GUARD_BITS);
    y = yr * (longint'(1) <<< GUARD_BITS);
    z = 0;
    if (xr == 0 && yr == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    // left half plane: flip the vector and start the angle at +/- pi
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end
    end
    mag = (x * longint'(INV_GAIN_Q22) + (longint'(1) <<< (MAG_SHIFT - 1))) >>> MAG_SHIFT;
    ang = (z + (longint'(1) <<< (ANGLE_FRAC - FB - 1))) >>> (ANGLE_FRAC - FB);
  endfunction

  function automatic longint clamp_part(input longint v, inout logic clipped);
    if (v > RES_MAX) begin
      clipped = 1'b1;
      return RES_MAX;
    end
    if (v < RES_MIN) begin
      clipped = 1'b1;
      return RES_MIN;
    end
    return v;
  endfunction

  function automatic cplx_result_t predict_result(input logic [OP_W-1:0] op,
                                                  input logic signed [DW-1:0] ar,
                                                  input logic signed [DW-1:0] ai,
                                                  input logic signed [DW-1:0] br,
                                                  input logic signed [DW-1:0] bi);
    cplx_result_t r;
    longint re_w;
    longint im_w;
    longint mag;
    longint ang;
    logic clipped;
    r = '0;
    re_w = 0;
    im_w = 0;
    clipped = 1'b0;
    case (op)
      OP_ADD: begin
        re_w = longint'(ar) + longint'(br);
        im_w = longint'(ai) + longint'(bi);
      end
      OP_SUB: begin
        re_w = longint'(ar) - longint'(br);
        im_w = longint'(ai) - longint'(bi);
      end
      OP_MUL: begin
        re_w = (longint'(ar) * longint'(br) - longint'(ai) * longint'(bi)
                + (longint'(1) <<< (FB - 1))) >>> FB;
        im_w = (longint'(ar) * longint'(bi) + longint'(ai) * longint'(br)
                + (longint'(1) <<< (FB - 1))) >>> FB;
      end
      OP_EQ: begin
        r.eq = (ar == br) && (ai == bi);
      end
      OP_MAG, OP_PHASE: begin
        vector_polar(longint'(ar), longint'(ai), mag, ang);
        re_w = (op == OP_MAG) ? mag : ang;
      end
      default: begin
      end
    endcase
    r.re  = DW'(clamp_part(re_w, clipped));
    r.im  = DW'(clamp_part(im_w, clipped));
    r.sat = clipped;
    return r;
  endfunction

  always @(posedge clk) begin
    cplx_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      expected_q.delete();
      fail_count    <= 0;
      pending       <= 0;
      checked_count <= 0;
      sat_count     <= 0;
      eq_count      <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_result(in_operation, in_a_re, in_a_im,
                                            in_b_re, in_b_im));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: re %0d im %0d",
                 out_res_re, out_res_im);
          errs = 1;
        end else begin
          want = expected_q.pop_front();
          if (out_res_re !== want.re) begin
            $error("res_re: expected %0d, got %0d", want.re, out_res_re);
            errs++;
          end
          if (out_res_im !== want.im) begin
            $error("res_im: expected %0d, got %0d", want.im, out_res_im);
            errs++;
          end
          if (out_equal !== want.eq) begin
            $error("equal: expected %0b, got %0b", want.eq, out_equal);
            errs++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
            errs++;
          end
          checked_count <= checked_count + 1;
          sat_count     <= sat_count + int'(want.sat);
          eq_count      <= eq_count + int'(want.eq);
        end
      end
      fail_count <= fail_count + errs;
      pending    <= expected_q.size();
    end
  end

endmodule

[test/testbench.sv]
module testbench import cau_pkg::*;;

  localparam int DW              = DATA_WIDTH_DEF;
  localparam int RANDOM_REQS     = 650;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = CORDIC_STEPS_DEF + 12;
  localparam int IDLE_LIMIT      = 1000;

  // codes the block leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [OP_W-1:0] OP_LIST [0:7] = '{
    OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_MAG, OP_PHASE, OP_SPARE_LO, OP_SPARE_HI
  };

  localparam logic signed [DW-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [DW-1:0] S_MIN = 16'sh8000;
  localparam logic signed [DW-1:0] ONE   = 16'sd4096;
  localparam logic signed [DW-1:0] EDGE_VALS [0:4] = '{S_MAX, S_MIN, 16'sd0, -16'sd1, 16'sd1};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = OP_ADD;
  logic signed [DW-1:0] in_a_re = '0;
  logic signed [DW-1:0] in_a_im = '0;
  logic signed [DW-1:0] in_b_re = '0;
  logic signed [DW-1:0] in_b_im = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_res_re;
  logic signed [DW-1:0] out_res_im;
  logic                 out_equal;
  logic                 out_saturated;

  int fail_count;
  int pending;
  int checked_count;
  int sat_count;
  int eq_count;
  int sent_count = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_arithmetic_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_a_re       (in_a_re),
    .in_a_im       (in_a_im),
    .in_b_re       (in_b_re),
    .in_b_im       (in_b_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res_re    (out_res_re),
    .out_res_im    (out_res_im),
    .out_equal     (out_equal),
    .out_saturated (out_saturated)
  );

  cau_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_a_re       (in_a_re),
    .in_a_im       (in_a_im),
    .in_b_re       (in_b_re),
    .in_b_im       (in_b_im),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res_re    (out_res_re),
    .out_res_im    (out_res_im),
    .out_equal     (out_equal),
    .out_saturated (out_saturated),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .sat_count     (sat_count),
    .eq_count      (eq_count)
  );

  // Offer one request after a random gap (none in the steady burst) and hold it until taken.
  task automatic send_req(input logic [OP_W-1:0] op,
                          input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
                          input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= op;
    in_a_re      <= ar;
    in_a_im      <= ai;
    in_b_re      <= br;
    in_b_im      <= bi;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic signed [DW-1:0] draw_operand();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom);
      1: v = int'($urandom_range(0, 8191)) - 4096;
      2: v = EDGE_VALS[$urandom_range(0, 4)];
      default: v = int'($urandom_range(0, 32767)) - 16384;
    endcase
    return DW'(v);
  endfunction

  task automatic send_random_req();
    int pick;
    logic [OP_W-1:0] op;
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] br;
    logic signed [DW-1:0] bi;
    pick = $urandom_range(0, 39);
    op = (pick < 38) ? OP_LIST[pick % 6] : OP_LIST[6 + pick - 38];
    ar = draw_operand();
    ai = draw_operand();
    br = draw_operand();
    bi = draw_operand();
    if (op == OP_EQ) begin
      case ($urandom_range(0, 2))
        0: begin
          br = ar;
          bi = ai;
        end
        1: br = ar;
        default: begin
        end
      endcase
    end
    if ((op == OP_MAG || op == OP_PHASE) && $urandom_range(0, 15) == 0) begin
      ar = '0;
      ai = '0;
    end
    send_req(op, ar, ai, br, bi);
  endtask

  // Sender: directed corners, then random traffic with a steady burst.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(OP_ADD,   S_MAX, S_MAX, S_MAX, S_MAX);
    send_req(OP_ADD,   S_MIN, S_MIN, S_MIN, S_MIN);
    send_req(OP_SUB,   S_MIN, S_MAX, S_MAX, S_MIN);
    send_req(OP_SUB,   16'sd0, 16'sd0, S_MIN, S_MIN);
    send_req(OP_SUB,   S_MAX, ONE, S_MAX, -ONE);
    send_req(OP_MUL,   ONE, 16'sd0, ONE, 16'sd0);
    send_req(OP_MUL,   16'sd0, ONE, 16'sd0, ONE);
    // half-LSB products that cancel or sum to a whole LSB
    send_req(OP_MUL,   16'sd1, -16'sd1, 16'sd2048, 16'sd2048);
    send_req(OP_MUL,   S_MIN, S_MIN, S_MIN, S_MAX);
    send_req(OP_MUL,   S_MAX, S_MIN, S_MAX, S_MAX);
    send_req(OP_EQ,    S_MIN, S_MAX, S_MIN, S_MAX);
    send_req(OP_EQ,    ONE, ONE, ONE, ONE + 16'sd1);
    send_req(OP_EQ,    16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_req(OP_MAG,   16'sd0, 16'sd0, S_MAX, S_MAX);
    send_req(OP_PHASE, 16'sd0, 16'sd0, ONE, ONE);
    send_req(OP_MAG,   S_MAX, S_MAX, 16'sd0, 16'sd0);
    send_req(OP_MAG,   S_MIN, S_MIN, 16'sd0, 16'sd0);
    send_req(OP_MAG,   S_MIN, 16'sd0, ONE, ONE);
    send_req(OP_PHASE, -ONE, 16'sd0, 16'sd0, 16'sd0);
    send_req(OP_PHASE, -ONE, -16'sd1, 16'sd0, 16'sd0);
    send_req(OP_PHASE, S_MIN, S_MAX, 16'sd0, 16'sd0);
    send_req(OP_PHASE, 16'sd0, ONE, 16'sd0, 16'sd0);
    send_req(OP_PHASE, 16'sd0, -ONE, 16'sd0, 16'sd0);
    send_req(OP_SPARE_LO, S_MAX, S_MAX, S_MAX, S_MAX);
    send_req(OP_SPARE_HI, S_MIN, ONE, ONE, ONE);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      steady = (n >= 300 && n < 420);
      send_random_req();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests over all operation codes, directed corners and random operands;",
             sent_count);
    $display("checked %0d results (%0d saturated, %0d equal).",
             checked_count, sat_count, eq_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs that back up the pipeline.
  initial begin
    int got;
    int stall;
    got = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (got == 150 || got == 360) begin
        stall = HOLD_OFF_CYCLES;
      end else if (steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got++;
    end
  end

  // Watchdog: end the run if no request or result moves for too long.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      idle_cycles <= 0;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
